// ----- rtl/stok_pkg.sv -----
// Shared types, constants and helper functions for the source tokenizer.
// No dependencies; used by every module of the tokenizer.
`timescale 1ns / 1ps

package stok_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int KEYWORD_CHARS_DEF = 7;
    localparam int MAX_RESULTS = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [5:0] K_IDENT      = 6'd0;
    localparam logic [5:0] K_INT        = 6'd1;
    localparam logic [5:0] K_FLOAT      = 6'd2;
    localparam logic [5:0] K_STRING     = 6'd3;
    localparam logic [5:0] K_STRCHAR    = 6'd4;
    localparam logic [5:0] K_KW_DEFINE  = 6'd5;
    localparam logic [5:0] K_KW_INT     = 6'd6;
    localparam logic [5:0] K_KW_STRING  = 6'd7;
    localparam logic [5:0] K_KW_BOOL    = 6'd8;
    localparam logic [5:0] K_KW_STRUCT  = 6'd9;
    localparam logic [5:0] K_KW_FLOAT   = 6'd10;
    localparam logic [5:0] K_KW_FUNC    = 6'd11;
    localparam logic [5:0] K_KW_RETURN  = 6'd12;
    localparam logic [5:0] K_KW_IF      = 6'd13;
    localparam logic [5:0] K_KW_ELSEIF  = 6'd14;
    localparam logic [5:0] K_KW_FOR     = 6'd15;
    localparam logic [5:0] K_KW_ELSE    = 6'd16;
    localparam logic [5:0] K_KW_TRUE    = 6'd17;
    localparam logic [5:0] K_KW_FALSE   = 6'd18;
    localparam logic [5:0] K_PLUS       = 6'd19;
    localparam logic [5:0] K_MINUS      = 6'd20;
    localparam logic [5:0] K_STAR       = 6'd21;
    localparam logic [5:0] K_SLASH      = 6'd22;
    localparam logic [5:0] K_PERCENT    = 6'd23;
    localparam logic [5:0] K_COLON      = 6'd24;
    localparam logic [5:0] K_SEMI       = 6'd25;
    localparam logic [5:0] K_COMMA      = 6'd26;
    localparam logic [5:0] K_DOT        = 6'd27;
    localparam logic [5:0] K_QUEST      = 6'd28;
    localparam logic [5:0] K_LPAREN     = 6'd29;
    localparam logic [5:0] K_RPAREN     = 6'd30;
    localparam logic [5:0] K_LBRACK     = 6'd31;
    localparam logic [5:0] K_RBRACK     = 6'd32;
    localparam logic [5:0] K_LBRACE     = 6'd33;
    localparam logic [5:0] K_RBRACE     = 6'd34;
    localparam logic [5:0] K_LESS       = 6'd35;
    localparam logic [5:0] K_LESS_EQ    = 6'd36;
    localparam logic [5:0] K_GREATER    = 6'd37;
    localparam logic [5:0] K_GREATER_EQ = 6'd38;
    localparam logic [5:0] K_EQ_EQ      = 6'd39;
    localparam logic [5:0] K_NOT_EQ     = 6'd40;
    localparam logic [5:0] K_AND        = 6'd41;
    localparam logic [5:0] K_OR         = 6'd42;
    localparam logic [5:0] K_END        = 6'd43;
    localparam logic [5:0] K_ERROR      = 6'd44;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_BAD_CHAR = 3'd1;
    localparam logic [2:0] E_LONE_EQ  = 3'd2;
    localparam logic [2:0] E_LONE_BANG = 3'd3;
    localparam logic [2:0] E_LONE_AMP = 3'd4;
    localparam logic [2:0] E_LONE_PIPE = 3'd5;
    localparam logic [2:0] E_OPEN_STR = 3'd6;
    localparam logic [2:0] E_OPEN_CMT = 3'd7;

    typedef enum logic [20:0] {
        M_IDLE   = 21'h000001,
        M_IDENT  = 21'h000002,
        M_NUM    = 21'h000004,
        M_NUMDOT = 21'h000008,
        M_FLOAT  = 21'h000010,
        M_MINUS1 = 21'h000020,
        M_MINUS2 = 21'h000040,
        M_SLASH1 = 21'h000080,
        M_LT     = 21'h000100,
        M_GT     = 21'h000200,
        M_EQ     = 21'h000400,
        M_BANG   = 21'h000800,
        M_AMP    = 21'h001000,
        M_PIPE   = 21'h002000,
        M_STR    = 21'h004000,
        M_STRESC = 21'h008000,
        M_LINEC  = 21'h010000,
        M_BC     = 21'h020000,
        M_BCBS   = 21'h040000,
        M_BCBSD  = 21'h080000,
        M_ERR    = 21'h100000
    } mode_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
            || (c == 8'h5f);
    endfunction

    // single-byte operator lookup; returns 1 on hit
    function automatic logic single_op(input logic [7:0] c, output logic [5:0] kind);
        logic hit;
        hit  = 1'b1;
        kind = K_PLUS;
        unique case (c)
            8'h2b: kind = K_PLUS;
            8'h2a: kind = K_STAR;
            8'h25: kind = K_PERCENT;
            8'h3a: kind = K_COLON;
            8'h3b: kind = K_SEMI;
            8'h2c: kind = K_COMMA;
            8'h2e: kind = K_DOT;
            8'h3f: kind = K_QUEST;
            8'h28: kind = K_LPAREN;
            8'h29: kind = K_RPAREN;
            8'h5b: kind = K_LBRACK;
            8'h5d: kind = K_RBRACK;
            8'h7b: kind = K_LBRACE;
            8'h7d: kind = K_RBRACE;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ----- rtl/source_tokenizer_core.sv -----
// Top level of the source tokenizer: front-end scanner plus result queue.
// Depends on stok_pkg, stok_front and stok_back.
//
// channel | dir | fields
// s_axis  | in  | tdata[7:0] src_byte, tlast end_of_source
// m_axis  | out | tdata token_kind..error_code, tlast last_of_run
//
// One byte is taken per cycle while the four-entry burst queue has room.
// Results leave one per cycle while the master accepts them; the queue
// absorbs the difference when a byte gives several results.
// Synchronous active-low reset returns scanner state and queue to empty.
`timescale 1ns / 1ps

module source_tokenizer_core #(
    parameter int POSITION_BITS = stok_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_CHARS = stok_pkg::KEYWORD_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] src_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] token_kind, [21:6] start_line, [37:22] start_column,
    // [53:38] lexeme_length, [61:54] string_char, [64:62] error_code
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int RW = 6 + 16 + 16 + 16 + 8 + 3;

    logic              q_room, rec_push;
    logic [2:0]        rec_count;
    logic [4*RW-1:0]   rec_data;
    logic [RW-1:0]     out_rec;

    stok_front #(
        .POSITION_BITS(POSITION_BITS),
        .KEYWORD_CHARS(KEYWORD_CHARS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .q_room    (q_room),
        .rec_push  (rec_push),
        .rec_count (rec_count),
        .rec_data  (rec_data)
    );

    stok_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_push  (rec_push),
        .rec_count (rec_count),
        .rec_data  (rec_data),
        .q_room    (q_room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rec   (out_rec),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, out_rec};

endmodule

// ----- rtl/stok_front.sv -----
// Front end: accepts source bytes, runs the scan state machine and emits
// up to four result records per byte into the result queue. Uses stok_pkg.
`timescale 1ns / 1ps

module stok_front #(
    parameter int POSITION_BITS = stok_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_CHARS = stok_pkg::KEYWORD_CHARS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                in_byte,
    input  logic                      in_last,
    input  logic                      q_room,
    output logic                      rec_push,
    output logic [2:0]                rec_count,
    output logic [4*(6+16+16+16+8+3)-1:0] rec_data
);

    localparam int RW = 6 + 16 + 16 + 16 + 8 + 3;
    localparam int PB = POSITION_BITS;
    localparam int WB = 8 * KEYWORD_CHARS;
    localparam logic [PB-1:0] PMAX = {PB{1'b1}};
    localparam logic [PB-1:0] PONE = {{(PB-1){1'b0}}, 1'b1};

    stok_pkg::mode_t   mode_reg, mode_next;
    logic [PB-1:0]     line_reg, line_next, col_reg, col_next;
    logic [PB-1:0]     tl_reg, tl_next, tc_reg, tc_next, len_reg, len_next;
    logic [WB-1:0]     win_reg, win_next;

    logic [RW-1:0]     rec [4];
    logic [2:0]        cnt;
    logic              go;

    assign in_ready = q_room;
    assign go       = in_valid && q_room;

    function automatic logic [PB-1:0] sinc(input logic [PB-1:0] v);
        return (v == PMAX) ? v : v + PONE;
    endfunction

    function automatic logic [RW-1:0] mk(input logic [5:0] k, input logic [PB-1:0] l,
                                         input logic [PB-1:0] c, input logic [PB-1:0] n,
                                         input logic [7:0] ch, input logic [2:0] e);
        logic [15:0] l16, c16, n16;
        l16 = 16'(l);
        c16 = 16'(c);
        n16 = 16'(n);
        return {e, ch, n16, c16, l16, k};
    endfunction

    function automatic logic [WB-1:0] push_win(input logic [WB-1:0] w, input logic [7:0] c);
        return {c, w[WB-1:8]};
    endfunction

    // keyword match over the window; index 0 of the window is the newest byte
    function automatic logic [5:0] kw_kind(input logic [WB-1:0] w, input logic [PB-1:0] n);
        logic [5:0] k;
        logic [7:0] b0, b1, b2, b3, b4, b5;
        k  = stok_pkg::K_IDENT;
        b0 = w[WB-1 -: 8];
        b1 = w[WB-9 -: 8];
        b2 = w[WB-17 -: 8];
        b3 = w[WB-25 -: 8];
        b4 = w[WB-33 -: 8];
        b5 = w[WB-41 -: 8];
        if (n == PB'(2)) begin
            if ({b1, b0} == "if") k = stok_pkg::K_KW_IF;
        end else if (n == PB'(3)) begin
            if ({b2, b1, b0} == "int") k = stok_pkg::K_KW_INT;
            else if ({b2, b1, b0} == "for") k = stok_pkg::K_KW_FOR;
        end else if (n == PB'(4)) begin
            if ({b3, b2, b1, b0} == "bool") k = stok_pkg::K_KW_BOOL;
            else if ({b3, b2, b1, b0} == "func") k = stok_pkg::K_KW_FUNC;
            else if ({b3, b2, b1, b0} == "else") k = stok_pkg::K_KW_ELSE;
            else if ({b3, b2, b1, b0} == "true") k = stok_pkg::K_KW_TRUE;
        end else if (n == PB'(5)) begin
            if ({b4, b3, b2, b1, b0} == "float") k = stok_pkg::K_KW_FLOAT;
            else if ({b4, b3, b2, b1, b0} == "false") k = stok_pkg::K_KW_FALSE;
        end else if (n == PB'(6)) begin
            if ({b5, b4, b3, b2, b1, b0} == "define") k = stok_pkg::K_KW_DEFINE;
            else if ({b5, b4, b3, b2, b1, b0} == "string") k = stok_pkg::K_KW_STRING;
            else if ({b5, b4, b3, b2, b1, b0} == "struct") k = stok_pkg::K_KW_STRUCT;
            else if ({b5, b4, b3, b2, b1, b0} == "return") k = stok_pkg::K_KW_RETURN;
            else if ({b5, b4, b3, b2, b1, b0} == "elseif") k = stok_pkg::K_KW_ELSEIF;
        end
        return k;
    endfunction

    always_comb begin
        logic [7:0]    c;
        logic [PB-1:0] ln, cl, tl, tc, flen, ftl, ftc;
        logic          idle_in;
        logic [5:0]    sk;
        stok_pkg::mode_t fm;

        c         = in_byte;
        ln        = line_reg;
        cl        = col_reg;
        tl        = tl_reg;
        tc        = tc_reg;
        mode_next = mode_reg;
        tl_next   = tl_reg;
        tc_next   = tc_reg;
        len_next  = len_reg;
        win_next  = win_reg;
        cnt       = 3'd0;
        idle_in   = 1'b0;
        sk        = stok_pkg::K_PLUS;
        for (int i = 0; i < 4; i++) rec[i] = '0;

        unique case (mode_reg)
            stok_pkg::M_IDLE: idle_in = 1'b1;
            stok_pkg::M_IDENT: begin
                if (stok_pkg::is_alpha(c) || stok_pkg::is_digit(c)) begin
                    len_next = sinc(len_reg);
                    win_next = push_win(win_reg, c);
                end else begin
                    rec[0] = mk(kw_kind(win_reg, len_reg), tl, tc, len_reg, 8'd0,
                                stok_pkg::E_NONE);
                    cnt = 3'd1;
                    idle_in = 1'b1;
                end
            end
            stok_pkg::M_NUM: begin
                if (stok_pkg::is_digit(c)) len_next = sinc(len_reg);
                else if (c == 8'h2e) begin
                    len_next = sinc(len_reg);
                    mode_next = stok_pkg::M_NUMDOT;
                end else begin
                    rec[0] = mk(stok_pkg::K_INT, tl, tc, len_reg, 8'd0, stok_pkg::E_NONE);
                    cnt = 3'd1;
                    idle_in = 1'b1;
                end
            end
            stok_pkg::M_NUMDOT: begin
                if (stok_pkg::is_digit(c)) begin
                    len_next = sinc(len_reg);
                    mode_next = stok_pkg::M_FLOAT;
                end else begin
                    rec[0] = mk(stok_pkg::K_INT, tl, tc, len_reg - PONE, 8'd0,
                                stok_pkg::E_NONE);
                    rec[1] = mk(stok_pkg::K_DOT, ln, (cl == '0) ? cl : cl - PONE, PONE,
                                8'd0, stok_pkg::E_NONE);
                    cnt = 3'd2;
                    idle_in = 1'b1;
                end
            end
            stok_pkg::M_FLOAT: begin
                if (stok_pkg::is_digit(c)) len_next = sinc(len_reg);
                else begin
                    rec[0] = mk(stok_pkg::K_FLOAT, tl, tc, len_reg, 8'd0, stok_pkg::E_NONE);
                    cnt = 3'd1;
                    idle_in = 1'b1;
                end
            end
            stok_pkg::M_MINUS1: begin
                if (c == 8'h2d) begin
                    len_next = PB'(2);
                    mode_next = stok_pkg::M_MINUS2;
                end else begin
                    rec[0] = mk(stok_pkg::K_MINUS, tl, tc, PONE, 8'd0, stok_pkg::E_NONE);
                    cnt = 3'd1;
                    idle_in = 1'b1;
                end
            end
            stok_pkg::M_MINUS2: begin
                if (c == 8'h2f) begin
                    len_next = PB'(3);
                    mode_next = stok_pkg::M_BC;
                end else if (c == 8'h2d) begin
                    rec[0] = mk(stok_pkg::K_MINUS, tl, tc, PONE, 8'd0, stok_pkg::E_NONE);
                    cnt = 3'd1;
                    tc_next = sinc(tc);
                end else begin
                    rec[0] = mk(stok_pkg::K_MINUS, tl, tc, PONE, 8'd0, stok_pkg::E_NONE);
                    rec[1] = mk(stok_pkg::K_MINUS, tl, sinc(tc), PONE, 8'd0,
                                stok_pkg::E_NONE);
                    cnt = 3'd2;
                    idle_in = 1'b1;
                end
            end
            stok_pkg::M_SLASH1: begin
                if (c == 8'h2f) mode_next = stok_pkg::M_LINEC;
                else begin
                    rec[0] = mk(stok_pkg::K_SLASH, tl, tc, PONE, 8'd0, stok_pkg::E_NONE);
                    cnt = 3'd1;
                    idle_in = 1'b1;
                end
            end
            stok_pkg::M_LT, stok_pkg::M_GT: begin
                if (c == 8'h3d) begin
                    rec[0] = mk((mode_reg == stok_pkg::M_LT) ? stok_pkg::K_LESS_EQ
                                : stok_pkg::K_GREATER_EQ, tl, tc, PB'(2), 8'd0,
                                stok_pkg::E_NONE);
                    cnt = 3'd1;
                    mode_next = stok_pkg::M_IDLE;
                end else begin
                    rec[0] = mk((mode_reg == stok_pkg::M_LT) ? stok_pkg::K_LESS
                                : stok_pkg::K_GREATER, tl, tc, PONE, 8'd0,
                                stok_pkg::E_NONE);
                    cnt = 3'd1;
                    idle_in = 1'b1;
                end
            end
            stok_pkg::M_EQ, stok_pkg::M_BANG, stok_pkg::M_AMP, stok_pkg::M_PIPE: begin
                logic [7:0] want;
                logic [5:0] pk;
                logic [2:0] pe;
                want = 8'h3d;
                pk = stok_pkg::K_EQ_EQ;
                pe = stok_pkg::E_LONE_EQ;
                if (mode_reg == stok_pkg::M_BANG) begin
                    pk = stok_pkg::K_NOT_EQ;
                    pe = stok_pkg::E_LONE_BANG;
                end else if (mode_reg == stok_pkg::M_AMP) begin
                    want = 8'h26;
                    pk = stok_pkg::K_AND;
                    pe = stok_pkg::E_LONE_AMP;
                end else if (mode_reg == stok_pkg::M_PIPE) begin
                    want = 8'h7c;
                    pk = stok_pkg::K_OR;
                    pe = stok_pkg::E_LONE_PIPE;
                end
                cnt = 3'd1;
                if (c == want) begin
                    rec[0] = mk(pk, tl, tc, PB'(2), 8'd0, stok_pkg::E_NONE);
                    mode_next = stok_pkg::M_IDLE;
                end else begin
                    rec[0] = mk(stok_pkg::K_ERROR, tl, tc, PONE, 8'd0, pe);
                    mode_next = stok_pkg::M_ERR;
                end
            end
            stok_pkg::M_STR: begin
                len_next = sinc(len_reg);
                cnt = 3'd1;
                if (c == 8'h22) begin
                    rec[0] = mk(stok_pkg::K_STRING, tl, tc, len_next, 8'd0, stok_pkg::E_NONE);
                    mode_next = stok_pkg::M_IDLE;
                end else if (c == 8'h5c) begin
                    cnt = 3'd0;
                    mode_next = stok_pkg::M_STRESC;
                end else begin
                    rec[0] = mk(stok_pkg::K_STRCHAR, tl, tc, len_next, c, stok_pkg::E_NONE);
                end
            end
            stok_pkg::M_STRESC: begin
                len_next = sinc(len_reg);
                rec[0] = mk(stok_pkg::K_STRCHAR, tl, tc, len_next,
                            (c == 8'h6e) ? 8'd10 : ((c == 8'h74) ? 8'd9 : c),
                            stok_pkg::E_NONE);
                cnt = 3'd1;
                mode_next = stok_pkg::M_STR;
            end
            stok_pkg::M_LINEC: begin
                if (c == 8'h0a) mode_next = stok_pkg::M_IDLE;
            end
            stok_pkg::M_BC, stok_pkg::M_BCBS, stok_pkg::M_BCBSD: begin
                len_next = sinc(len_reg);
                if (c == 8'h5c) mode_next = stok_pkg::M_BCBS;
                else if (c == 8'h2d && mode_reg == stok_pkg::M_BCBS)
                    mode_next = stok_pkg::M_BCBSD;
                else if (c == 8'h2d && mode_reg == stok_pkg::M_BCBSD)
                    mode_next = stok_pkg::M_IDLE;
                else mode_next = stok_pkg::M_BC;
            end
            stok_pkg::M_ERR: mode_next = stok_pkg::M_ERR;
            default: mode_next = stok_pkg::M_ERR;
        endcase

        if (idle_in) begin
            mode_next = stok_pkg::M_IDLE;
            if (c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
                mode_next = stok_pkg::M_IDLE;
            end else if (stok_pkg::single_op(c, sk)) begin
                rec[cnt[1:0]] = mk(sk, ln, cl, PONE, 8'd0, stok_pkg::E_NONE);
                cnt = cnt + 3'd1;
            end else begin
                tl_next  = ln;
                tc_next  = cl;
                len_next = PONE;
                priority case (1'b1)
                    c == 8'h2d: mode_next = stok_pkg::M_MINUS1;
                    c == 8'h2f: mode_next = stok_pkg::M_SLASH1;
                    c == 8'h3c: mode_next = stok_pkg::M_LT;
                    c == 8'h3e: mode_next = stok_pkg::M_GT;
                    c == 8'h3d: mode_next = stok_pkg::M_EQ;
                    c == 8'h21: mode_next = stok_pkg::M_BANG;
                    c == 8'h26: mode_next = stok_pkg::M_AMP;
                    c == 8'h7c: mode_next = stok_pkg::M_PIPE;
                    c == 8'h22: mode_next = stok_pkg::M_STR;
                    stok_pkg::is_digit(c): mode_next = stok_pkg::M_NUM;
                    stok_pkg::is_alpha(c): begin
                        mode_next = stok_pkg::M_IDENT;
                        win_next  = {c, {(WB-8){1'b0}}};
                    end
                    default: begin
                        tl_next  = tl_reg;
                        tc_next  = tc_reg;
                        len_next = len_reg;
                        rec[cnt[1:0]] = mk(stok_pkg::K_ERROR, ln, cl, PONE, 8'd0,
                                           stok_pkg::E_BAD_CHAR);
                        cnt = cnt + 3'd1;
                        mode_next = stok_pkg::M_ERR;
                    end
                endcase
            end
        end

        if (c == 8'h0a) begin
            line_next = sinc(line_reg);
            col_next  = PONE;
        end else begin
            line_next = line_reg;
            col_next  = sinc(col_reg);
        end

        if (in_last) begin
            fm   = mode_next;
            ftl  = tl_next;
            ftc  = tc_next;
            flen = len_next;
            unique case (fm)
                stok_pkg::M_IDENT: begin
                    rec[cnt[1:0]] = mk(kw_kind(win_next, flen), ftl, ftc, flen, 8'd0,
                                       stok_pkg::E_NONE);
                    cnt = cnt + 3'd1;
                end
                stok_pkg::M_NUM: begin
                    rec[cnt[1:0]] = mk(stok_pkg::K_INT, ftl, ftc, flen, 8'd0,
                                       stok_pkg::E_NONE);
                    cnt = cnt + 3'd1;
                end
                stok_pkg::M_NUMDOT: begin
                    rec[cnt[1:0]] = mk(stok_pkg::K_INT, ftl, ftc, flen - PONE, 8'd0,
                                       stok_pkg::E_NONE);
                    rec[2'(cnt + 3'd1)] = mk(stok_pkg::K_DOT, ftl, ftc + flen - PONE, PONE,
                                             8'd0, stok_pkg::E_NONE);
                    cnt = cnt + 3'd2;
                end
                stok_pkg::M_FLOAT: begin
                    rec[cnt[1:0]] = mk(stok_pkg::K_FLOAT, ftl, ftc, flen, 8'd0,
                                       stok_pkg::E_NONE);
                    cnt = cnt + 3'd1;
                end
                stok_pkg::M_MINUS1: begin
                    rec[cnt[1:0]] = mk(stok_pkg::K_MINUS, ftl, ftc, PONE, 8'd0,
                                       stok_pkg::E_NONE);
                    cnt = cnt + 3'd1;
                end
                stok_pkg::M_MINUS2: begin
                    rec[cnt[1:0]] = mk(stok_pkg::K_MINUS, ftl, ftc, PONE, 8'd0,
                                       stok_pkg::E_NONE);
                    rec[2'(cnt + 3'd1)] = mk(stok_pkg::K_MINUS, ftl, sinc(ftc), PONE,
                                             8'd0, stok_pkg::E_NONE);
                    cnt = cnt + 3'd2;
                end
                stok_pkg::M_SLASH1: begin
                    rec[cnt[1:0]] = mk(stok_pkg::K_SLASH, ftl, ftc, PONE, 8'd0,
                                       stok_pkg::E_NONE);
                    cnt = cnt + 3'd1;
                end
                stok_pkg::M_LT: begin
                    rec[cnt[1:0]] = mk(stok_pkg::K_LESS, ftl, ftc, PONE, 8'd0,
                                       stok_pkg::E_NONE);
                    cnt = cnt + 3'd1;
                end
                stok_pkg::M_GT: begin
                    rec[cnt[1:0]] = mk(stok_pkg::K_GREATER, ftl, ftc, PONE, 8'd0,
                                       stok_pkg::E_NONE);
                    cnt = cnt + 3'd1;
                end
                stok_pkg::M_EQ, stok_pkg::M_BANG, stok_pkg::M_AMP, stok_pkg::M_PIPE: begin
                    rec[cnt[1:0]] = mk(stok_pkg::K_ERROR, ftl, ftc, PONE, 8'd0,
                        (fm == stok_pkg::M_EQ) ? stok_pkg::E_LONE_EQ :
                        (fm == stok_pkg::M_BANG) ? stok_pkg::E_LONE_BANG :
                        (fm == stok_pkg::M_AMP) ? stok_pkg::E_LONE_AMP :
                        stok_pkg::E_LONE_PIPE);
                    cnt = cnt + 3'd1;
                end
                stok_pkg::M_STR, stok_pkg::M_STRESC: begin
                    rec[cnt[1:0]] = mk(stok_pkg::K_ERROR, ftl, ftc, flen, 8'd0,
                                       stok_pkg::E_OPEN_STR);
                    cnt = cnt + 3'd1;
                end
                stok_pkg::M_BC, stok_pkg::M_BCBS, stok_pkg::M_BCBSD: begin
                    rec[cnt[1:0]] = mk(stok_pkg::K_ERROR, ftl, ftc, flen, 8'd0,
                                       stok_pkg::E_OPEN_CMT);
                    cnt = cnt + 3'd1;
                end
                stok_pkg::M_IDLE, stok_pkg::M_LINEC, stok_pkg::M_ERR: ;
                default: ;
            endcase
            // the end marker only when no error is pending
            if (!(fm == stok_pkg::M_ERR || fm == stok_pkg::M_EQ || fm == stok_pkg::M_BANG
                  || fm == stok_pkg::M_AMP || fm == stok_pkg::M_PIPE || fm == stok_pkg::M_STR
                  || fm == stok_pkg::M_STRESC || fm == stok_pkg::M_BC
                  || fm == stok_pkg::M_BCBS || fm == stok_pkg::M_BCBSD)) begin
                rec[cnt[1:0]] = mk(stok_pkg::K_END, line_next, col_next, '0, 8'd0,
                                   stok_pkg::E_NONE);
                cnt = cnt + 3'd1;
            end
            mode_next = stok_pkg::M_IDLE;
            line_next = PONE;
            col_next  = PONE;
            tl_next   = PONE;
            tc_next   = '0;
            len_next  = '0;
            win_next  = '0;
        end
    end

    assign rec_push  = go && (cnt != 3'd0);
    assign rec_count = cnt;
    assign rec_data  = {rec[3], rec[2], rec[1], rec[0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= stok_pkg::M_IDLE;
            line_reg <= PONE;
            col_reg  <= PONE;
            tl_reg   <= PONE;
            tc_reg   <= '0;
            len_reg  <= '0;
            win_reg  <= '0;
        end else if (go) begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            tl_reg   <= tl_next;
            tc_reg   <= tc_next;
            len_reg  <= len_next;
            win_reg  <= win_next;
        end
    end

endmodule

// ----- rtl/stok_back.sv -----
// Back end: queue of front-end result bursts, drained to the master stream
// one result per cycle while out_ready is high; tlast ends each burst.
`timescale 1ns / 1ps

module stok_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rec_push,
    input  logic [2:0]                    rec_count,
    input  logic [4*(6+16+16+16+8+3)-1:0] rec_data,
    output logic                          q_room,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [6+16+16+16+8+3-1:0]     out_rec,
    output logic                          out_last
);

    localparam int RW = 6 + 16 + 16 + 16 + 8 + 3;
    localparam int QD = stok_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(QD);

    logic [4*RW-1:0] burst_mem [QD];
    logic [2:0]      cnt_mem [QD];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     fill_reg;
    logic [1:0]      sub_reg;
    logic            pop, pop_burst;
    logic [2:0]      head_cnt;

    assign q_room    = fill_reg != (AW+1)'(QD);
    assign out_valid = fill_reg != '0;
    assign head_cnt  = cnt_mem[rp_reg];
    assign out_rec   = burst_mem[rp_reg][sub_reg*RW +: RW];
    assign out_last  = ({1'b0, sub_reg} + 3'd1) == head_cnt;
    assign pop       = out_valid && out_ready;
    assign pop_burst = pop && out_last;

    always_ff @(posedge aclk) begin
        if (rec_push) begin
            burst_mem[wp_reg] <= rec_data;
            cnt_mem[wp_reg]   <= rec_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
            sub_reg  <= '0;
        end else begin
            if (rec_push) wp_reg <= wp_reg + AW'(1);
            if (pop_burst) begin
                rp_reg  <= rp_reg + AW'(1);
                sub_reg <= '0;
            end else if (pop) begin
                sub_reg <= sub_reg + 2'd1;
            end
            fill_reg <= fill_reg + (AW+1)'(rec_push) - (AW+1)'(pop_burst);
        end
    end

endmodule
